// File: design/urb_pkg.sv
// Shared types and constants for the UART transmit/receive ring buffer.
// No dependencies.
package urb_pkg;

  localparam int unsigned TxDepthDef = 64;
  localparam int unsigned RxDepthDef = 64;
  localparam int unsigned LevelW     = 7;

  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam logic [7:0] LF_BYTE = 8'h0A;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_RX    = 2'd2,
    OP_READY = 2'd3
  } urb_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DONE = 1'b1
  } urb_state_e;

  // result of one event, minus the bytes that come back from the rings
  typedef struct packed {
    logic       tx_valid;
    logic       tx_mem;
    logic [7:0] tx_byte;
    logic       rd_valid;
    logic       dropped;
    logic       wr2;
  } urb_pend_t;

endpackage

// File: design/urb_ram.sv
// Byte ring storage: one write port, one read port, registered read data.
// Depends on urb_pkg.
module urb_ram
  import urb_pkg::*;
#(
  parameter int unsigned Depth = TxDepthDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/uart_ring_buffer_crlf_core.sv
// UART transmit/receive ring buffer with optional CR-before-LF expansion.
// The accepted event waits in S_DONE and loads the output register when free.
// No new event is accepted until that load, since in_ready is high only in S_IDLE.
// Reset: pointers, counts and busy flag cleared, crlf_q set to 1;
// ring contents are not initialized. Depends on urb_pkg and urb_ram.
module uart_ring_buffer_crlf_core
  import urb_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TxDepthDef,
  parameter int unsigned RX_DEPTH = RxDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [7:0]        data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              tx_valid_o,
  output logic [7:0]        tx_byte_o,
  output logic              rd_valid_o,
  output logic [7:0]        rd_byte_o,
  output logic              dropped_o,
  output logic              tx_is_full_o,
  output logic              tx_busy_o,
  output logic [LevelW-1:0] rx_level_o,
  output logic [LevelW-1:0] tx_level_o
);

  localparam int unsigned TPW = $clog2(TX_DEPTH);
  localparam int unsigned TCW = $clog2(TX_DEPTH + 1);
  localparam int unsigned RPW = $clog2(RX_DEPTH);
  localparam int unsigned RCW = $clog2(RX_DEPTH + 1);
  localparam logic [TCW-1:0] TX_FULL = TCW'(TX_DEPTH);
  localparam logic [RCW-1:0] RX_FULL = RCW'(RX_DEPTH);
  localparam logic [TPW-1:0] TX_LAST = TPW'(TX_DEPTH - 1);
  localparam logic [RPW-1:0] RX_LAST = RPW'(RX_DEPTH - 1);

  function automatic logic [TPW-1:0] tx_wrap(logic [TPW-1:0] head, logic [TCW-1:0] off);
    logic [TCW:0] s;
    s = (TCW+1)'(head) + (TCW+1)'(off);
    if (s >= (TCW+1)'(TX_DEPTH)) begin
      s = s - (TCW+1)'(TX_DEPTH);
    end
    return s[TPW-1:0];
  endfunction

  function automatic logic [RPW-1:0] rx_wrap(logic [RPW-1:0] head, logic [RCW-1:0] off);
    logic [RCW:0] s;
    s = (RCW+1)'(head) + (RCW+1)'(off);
    if (s >= (RCW+1)'(RX_DEPTH)) begin
      s = s - (RCW+1)'(RX_DEPTH);
    end
    return s[RPW-1:0];
  endfunction

  urb_state_e     state_q, state_d;
  logic           crlf_q;
  logic [TPW-1:0] tx_head_q, tx_head_d;
  logic [TCW-1:0] tx_cnt_q, tx_cnt_d;
  logic           tx_act_q, tx_act_d;
  logic [RPW-1:0] rx_head_q, rx_head_d;
  logic [RCW-1:0] rx_cnt_q, rx_cnt_d;
  urb_pend_t      pend_q, pend_d;
  logic [TPW-1:0] wr2_addr_q, wr2_addr_d;
  logic [7:0]     wr2_data_q, wr2_data_d;

  logic           tx_we, tx_re, rx_we, rx_re;
  logic [TPW-1:0] tx_waddr;
  logic [7:0]     tx_wdata, tx_rdata, rx_rdata;
  logic           load;

  // put evaluation: CR first when expanding, then the data byte
  logic [TCW-1:0] p_cnt;
  logic           p_act, p_line, p_drop;
  logic [1:0]     p_nq;
  logic [7:0]     p_qa, p_qb, p_lb;

  logic           out_valid_q, tx_valid_q, rd_valid_q, dropped_q, full_q, busy_q;
  logic [7:0]     tx_byte_q, rd_byte_q;
  logic [LevelW-1:0] rxl_q, txl_q;

  always_comb begin
    p_cnt  = tx_cnt_q;
    p_act  = tx_act_q;
    p_nq   = 2'd0;
    p_qa   = data_i;
    p_qb   = data_i;
    p_line = 1'b0;
    p_lb   = data_i;
    p_drop = 1'b0;
    if (crlf_q && data_i == LF_BYTE) begin
      if (p_cnt == TX_FULL) begin
        p_drop = 1'b1;
      end else if (!p_act) begin
        p_act  = 1'b1;
        p_line = 1'b1;
        p_lb   = CR_BYTE;
      end else begin
        p_qa  = CR_BYTE;
        p_nq  = 2'd1;
        p_cnt = p_cnt + TCW'(1);
      end
    end
    if (p_cnt == TX_FULL) begin
      p_drop = 1'b1;
    end else if (!p_act) begin
      p_act  = 1'b1;
      p_line = 1'b1;
      p_lb   = data_i;
    end else begin
      if (p_nq == 2'd0) begin
        p_qa = data_i;
      end else begin
        p_qb = data_i;
      end
      p_nq  = p_nq + 2'd1;
      p_cnt = p_cnt + TCW'(1);
    end
  end

  always_comb begin
    state_d    = state_q;
    tx_head_d  = tx_head_q;
    tx_cnt_d   = tx_cnt_q;
    tx_act_d   = tx_act_q;
    rx_head_d  = rx_head_q;
    rx_cnt_d   = rx_cnt_q;
    pend_d     = pend_q;
    wr2_addr_d = wr2_addr_q;
    wr2_data_d = wr2_data_q;
    tx_we      = 1'b0;
    tx_waddr   = tx_wrap(tx_head_q, tx_cnt_q);
    tx_wdata   = p_qa;
    tx_re      = 1'b0;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    load       = 1'b0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pend_d  = '0;
          state_d = S_DONE;
          case (urb_op_e'(op_i))
            OP_PUT: begin
              tx_cnt_d        = p_cnt;
              tx_act_d        = p_act;
              tx_we           = (p_nq != 2'd0);
              pend_d.tx_valid = p_line;
              pend_d.tx_byte  = p_lb;
              pend_d.dropped  = p_drop;
              pend_d.wr2      = (p_nq == 2'd2);
              wr2_addr_d      = tx_wrap(tx_head_q, tx_cnt_q + TCW'(1));
              wr2_data_d      = p_qb;
            end
            OP_GET: begin
              if (rx_cnt_q != '0) begin
                rx_re           = 1'b1;
                rx_head_d       = (rx_head_q == RX_LAST) ? '0 : rx_head_q + RPW'(1);
                rx_cnt_d        = rx_cnt_q - RCW'(1);
                pend_d.rd_valid = 1'b1;
              end
            end
            OP_RX: begin
              if (rx_cnt_q == RX_FULL) begin
                pend_d.dropped = 1'b1;
              end else begin
                rx_we    = 1'b1;
                rx_cnt_d = rx_cnt_q + RCW'(1);
              end
            end
            OP_READY: begin
              if (tx_cnt_q != '0) begin
                tx_re           = 1'b1;
                tx_head_d       = (tx_head_q == TX_LAST) ? '0 : tx_head_q + TPW'(1);
                tx_cnt_d        = tx_cnt_q - TCW'(1);
                tx_act_d        = 1'b1;
                pend_d.tx_valid = 1'b1;
                pend_d.tx_mem   = 1'b1;
              end else begin
                tx_act_d = 1'b0;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        // second queued byte of an expanded newline; rewrite while stalled is harmless
        if (pend_q.wr2) begin
          tx_we    = 1'b1;
          tx_waddr = wr2_addr_q;
          tx_wdata = wr2_data_q;
        end
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      crlf_q    <= 1'b1;
      tx_head_q <= '0;
      tx_cnt_q  <= '0;
      tx_act_q  <= 1'b0;
      rx_head_q <= '0;
      rx_cnt_q  <= '0;
      pend_q    <= '0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        crlf_q <= cfg_wdata_i;
      end
      tx_head_q <= tx_head_d;
      tx_cnt_q  <= tx_cnt_d;
      tx_act_q  <= tx_act_d;
      rx_head_q <= rx_head_d;
      rx_cnt_q  <= rx_cnt_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr2_addr_q <= wr2_addr_d;
    wr2_data_q <= wr2_data_d;
  end

  urb_ram #(.Depth(TX_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  urb_ram #(.Depth(RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wrap(rx_head_q, rx_cnt_q)),
    .wdata_i (data_i),
    .re_i    (rx_re),
    .raddr_i (rx_head_q),
    .rdata_o (rx_rdata)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_valid_q <= pend_q.tx_valid;
      tx_byte_q  <= !pend_q.tx_valid ? 8'h00 : (pend_q.tx_mem ? tx_rdata : pend_q.tx_byte);
      rd_valid_q <= pend_q.rd_valid;
      rd_byte_q  <= pend_q.rd_valid ? rx_rdata : 8'h00;
      dropped_q  <= pend_q.dropped;
      full_q     <= (tx_cnt_q == TX_FULL);
      busy_q     <= tx_act_q;
      rxl_q      <= LevelW'(rx_cnt_q);
      txl_q      <= LevelW'(tx_cnt_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_valid_o   = tx_valid_q;
  assign tx_byte_o    = tx_byte_q;
  assign rd_valid_o   = rd_valid_q;
  assign rd_byte_o    = rd_byte_q;
  assign dropped_o    = dropped_q;
  assign tx_is_full_o = full_q;
  assign tx_busy_o    = busy_q;
  assign rx_level_o   = rxl_q;
  assign tx_level_o   = txl_q;

  a_tx_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_cnt_q <= TX_FULL)
    else $error("tx count above depth");

  a_rx_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cnt_q <= RX_FULL)
    else $error("rx count above depth");

  a_tx_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tx_we && tx_re))
    else $error("tx ring read and write in one cycle");

  a_rx_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i == OP_RX && rx_cnt_q != RX_FULL)
      |=> rx_cnt_q == $past(rx_cnt_q) + RCW'(1))
    else $error("rx push did not advance count");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (state_q == S_DONE && (!out_valid_q || out_ready_i)))
    else $error("output word overwritten");

endmodule

// File: bench/tb_uart_ring_buffer_crlf_core.sv
// Self-checking bench for uart_ring_buffer_crlf_core: random-stall valid/ready
// driver and monitor checked against an in-bench model of both rings.
// Depends on urb_pkg and the core RTL.
module tb_uart_ring_buffer_crlf_core;
  timeunit 1ns;
  timeprecision 1ps;

  import urb_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    urb_op_e    op;
    logic [7:0] data;
  } ring_event_t;

  typedef struct packed {
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              rd_valid;
    logic [7:0]        rd_byte;
    logic              dropped;
    logic              tx_full;
    logic              tx_busy;
    logic [LevelW-1:0] rx_level;
    logic [LevelW-1:0] tx_level;
  } ring_status_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [1:0]        op_i        = 2'd0;
  logic [7:0]        data_i      = 8'd0;
  logic              out_ready_i = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              tx_valid_o;
  logic [7:0]        tx_byte_o;
  logic              rd_valid_o;
  logic [7:0]        rd_byte_o;
  logic              dropped_o;
  logic              tx_is_full_o;
  logic              tx_busy_o;
  logic [LevelW-1:0] rx_level_o;
  logic [LevelW-1:0] tx_level_o;

  uart_ring_buffer_crlf_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_valid_o  (tx_valid_o),
    .tx_byte_o   (tx_byte_o),
    .rd_valid_o  (rd_valid_o),
    .rd_byte_o   (rd_byte_o),
    .dropped_o   (dropped_o),
    .tx_is_full_o(tx_is_full_o),
    .tx_busy_o   (tx_busy_o),
    .rx_level_o  (rx_level_o),
    .tx_level_o  (tx_level_o)
  );

  always #4 clk_i = ~clk_i;

  // model of the rings
  logic [7:0]  tx_mem [TxDepthDef];
  logic [7:0]  rx_mem [RxDepthDef];
  int unsigned tx_hd, tx_cnt, rx_hd, rx_cnt;
  bit          tx_act;
  bit          crlf_on;

  ring_event_t  pending_events[$];
  ring_status_t predicted_status[$];

  bit          run_started = 1'b0;
  bit          calm        = 1'b0;
  bit          word_taken  = 1'b0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned cycles      = 0;
  int unsigned errors      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_dropped   = 0;
  int unsigned n_reads     = 0;
  int unsigned n_sent      = 0;

  function automatic bit tx_accept(input logic [7:0] b, inout ring_status_t r);
    if (tx_cnt >= TxDepthDef) return 1'b0;
    if (!tx_act) begin
      tx_act     = 1'b1;
      r.tx_valid = 1'b1;
      r.tx_byte  = b;
    end else begin
      tx_mem[(tx_hd + tx_cnt) % TxDepthDef] = b;
      tx_cnt++;
    end
    return 1'b1;
  endfunction

  function automatic ring_status_t advance_rings(input urb_op_e op, input logic [7:0] data);
    ring_status_t r;
    r = '0;
    case (op)
      OP_PUT: begin
        if (crlf_on && data == LF_BYTE) begin
          if (!tx_accept(CR_BYTE, r)) r.dropped = 1'b1;
        end
        if (!tx_accept(data, r)) r.dropped = 1'b1;
      end
      OP_GET: begin
        if (rx_cnt != 0) begin
          r.rd_valid = 1'b1;
          r.rd_byte  = rx_mem[rx_hd];
          rx_hd      = (rx_hd + 1) % RxDepthDef;
          rx_cnt--;
        end
      end
      OP_RX: begin
        if (rx_cnt >= RxDepthDef) begin
          r.dropped = 1'b1;
        end else begin
          rx_mem[(rx_hd + rx_cnt) % RxDepthDef] = data;
          rx_cnt++;
        end
      end
      default: begin
        if (tx_cnt != 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = tx_mem[tx_hd];
          tx_hd      = (tx_hd + 1) % TxDepthDef;
          tx_cnt--;
          tx_act     = 1'b1;
        end else begin
          tx_act = 1'b0;
        end
      end
    endcase
    r.tx_full  = (tx_cnt >= TxDepthDef);
    r.tx_busy  = tx_act;
    r.rx_level = LevelW'(rx_cnt);
    r.tx_level = LevelW'(tx_cnt);
    return r;
  endfunction

  task automatic cmp_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp, act);
      errors++;
    end
  endtask

  // sample side: config mirror, result check, prediction on accept
  always @(posedge clk_i) begin : monitor
    ring_status_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d words still expected", $time, predicted_status.size());
      $display("TEST FAILED");
      $finish;
    end
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (cfg_we_i) crlf_on = cfg_wdata_i;
      if (out_valid_o && out_ready_i) begin
        if (predicted_status.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got tx=%0b/%0h rd=%0b/%0h",
                   $time, tx_valid_o, tx_byte_o, rd_valid_o, rd_byte_o);
          errors++;
        end else begin
          e = predicted_status.pop_front();
          cmp_field("tx_valid", e.tx_valid, tx_valid_o);
          cmp_field("tx_byte", e.tx_byte, tx_byte_o);
          cmp_field("rd_valid", e.rd_valid, rd_valid_o);
          cmp_field("rd_byte", e.rd_byte, rd_byte_o);
          cmp_field("dropped", e.dropped, dropped_o);
          cmp_field("tx_is_full", e.tx_full, tx_is_full_o);
          cmp_field("tx_busy", e.tx_busy, tx_busy_o);
          cmp_field("rx_level", e.rx_level, rx_level_o);
          cmp_field("tx_level", e.tx_level, tx_level_o);
          n_checked++;
          if (e.dropped) n_dropped++;
          if (e.rd_valid) n_reads++;
          if (e.tx_valid) n_sent++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        predicted_status.push_back(advance_rings(urb_op_e'(op_i), data_i));
      end
      word_taken <= in_valid_i && in_ready_o;
    end
  end

  // drive side: inputs change on the falling edge
  always @(negedge clk_i) begin : driver
    ring_event_t w;
    logic        nv;
    logic [1:0]  nop;
    logic [7:0]  nd;
    logic        nrdy;
    nv   = in_valid_i;
    nop  = op_i;
    nd   = data_i;
    nrdy = 1'b1;
    if (run_started) begin
      if (!(in_valid_i && !word_taken)) begin
        nv = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_events.size() != 0) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 18) - 1;
          end else begin
            w   = pending_events.pop_front();
            nv  = 1'b1;
            nop = w.op;
            nd  = w.data;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        nrdy = 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        nrdy = 1'b0;
      end
    end else begin
      nrdy = 1'b0;
    end
    in_valid_i  <= nv;
    op_i        <= nop;
    data_i      <= nd;
    out_ready_i <= nrdy;
  end

  task automatic add_event(input urb_op_e op, input logic [7:0] data);
    ring_event_t w;
    w.op   = op;
    w.data = data;
    pending_events.push_back(w);
  endtask

  task automatic add_mix(input int unsigned n, input int unsigned put_w,
                         input int unsigned get_w, input int unsigned rx_w,
                         input int unsigned rdy_w);
    int unsigned pick;
    logic [7:0]  d;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, put_w + get_w + rx_w + rdy_w - 1);
      d    = 8'($urandom_range(0, 255));
      if (pick < put_w) begin
        if ($urandom_range(0, 3) == 0) d = LF_BYTE;
        add_event(OP_PUT, d);
      end else if (pick < put_w + get_w) begin
        add_event(OP_GET, d);
      end else if (pick < put_w + get_w + rx_w) begin
        add_event(OP_RX, d);
      end else begin
        add_event(OP_READY, d);
      end
    end
  endtask

  // drain the transmitter, fill the ring to the brim, then hit it when full
  task automatic fill_tx_ring();
    logic [7:0] d;
    for (int i = 0; i < 66; i++) add_event(OP_READY, 8'($urandom_range(0, 255)));
    for (int i = 0; i < 64; i++) begin
      do d = 8'($urandom_range(0, 255)); while (d == LF_BYTE);
      add_event(OP_PUT, d);
    end
    add_event(OP_PUT, LF_BYTE);
    add_event(OP_PUT, LF_BYTE);
    add_event(OP_PUT, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_quiet();
    while (pending_events.size() != 0 || in_valid_i || predicted_status.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_crlf(input logic v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    tx_hd   = 0;
    tx_cnt  = 0;
    rx_hd   = 0;
    rx_cnt  = 0;
    tx_act  = 1'b0;
    crlf_on = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_started = 1'b1;
    write_crlf(1'b1);

    // directed: empty rings, idle put, CR expansion, byte extremes
    add_event(OP_GET, 8'hFF);
    add_event(OP_READY, 8'h00);
    add_event(OP_PUT, 8'h00);
    add_event(OP_PUT, 8'hFF);
    add_event(OP_PUT, LF_BYTE);
    add_event(OP_READY, 8'hFF);
    add_event(OP_READY, 8'h00);
    add_event(OP_READY, 8'h00);
    add_event(OP_READY, 8'h00);
    add_event(OP_PUT, LF_BYTE);
    add_event(OP_READY, 8'h00);
    add_event(OP_READY, 8'h00);
    add_event(OP_RX, 8'h00);
    add_event(OP_RX, 8'hFF);
    add_event(OP_RX, LF_BYTE);
    add_event(OP_GET, 8'h00);
    add_event(OP_GET, 8'h00);
    add_event(OP_GET, 8'h00);
    add_event(OP_GET, 8'hA5);
    wait_quiet();

    write_crlf(1'b0);
    add_event(OP_PUT, LF_BYTE);
    add_event(OP_PUT, LF_BYTE);
    add_event(OP_READY, 8'h00);
    add_event(OP_READY, 8'h00);
    add_event(OP_READY, 8'h00);
    wait_quiet();

    write_crlf(1'b1);
    fill_tx_ring();
    add_mix(60, 3, 2, 2, 3);
    for (int i = 0; i < 66; i++) add_event(OP_GET, 8'($urandom_range(0, 255)));
    for (int i = 0; i < 66; i++) add_event(OP_RX, 8'($urandom_range(0, 255)));
    add_mix(40, 1, 6, 1, 2);
    wait_quiet();

    write_crlf(1'b0);
    fill_tx_ring();
    add_mix(40, 6, 1, 1, 2);
    wait_quiet();

    write_crlf(1'b1);
    calm       = 1'b1;
    gap_left   = 0;
    stall_left = 0;
    add_mix(60, 1, 1, 1, 1);
    wait_quiet();
    repeat (10) @(posedge clk_i);

    $display("Checked %0d result words: %0d drops, %0d ring reads, %0d line sends,",
             n_checked, n_dropped, n_reads, n_sent);
    $display("across both CR expansion settings with full and empty rings on both sides.");
    if (errors == 0 && predicted_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/urb_pkg.sv
design/urb_ram.sv
design/uart_ring_buffer_crlf_core.sv
bench/tb_uart_ring_buffer_crlf_core.sv
